>>> hdl/dsc_pkg.sv
// Shared types and constants for the domain suffix classifier.
// No dependencies; the interface, front, back and top files refer to it by scoped names.
package dsc_pkg;

    localparam int CHAR_W = 8;
    localparam int LEN_W  = 6;
    localparam int APP_W  = 5;
    localparam int IDX_W  = 6;
    localparam int POS_W  = 5;

    localparam logic [LEN_W-1:0]  LEN_SAT  = 6'd63;
    localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;
    localparam logic [CHAR_W-1:0] UPPER_A  = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

    localparam logic KIND_NAME = 1'b0;
    localparam logic KIND_RULE = 1'b1;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SLOT,
        BK_CMP,
        BK_DONE
    } t_back_state;

    // rule table write command, front to back
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  slot;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic [APP_W-1:0]  app;
    } t_rule_wr;

    // back status seen by the front
    typedef struct packed {
        logic idle;
    } t_back_status;

endpackage

>>> hdl/dsc_if.sv
// Valid/ready channel interfaces for the classifier input and result.
// Depends on dsc_pkg for field widths.
interface dsc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [dsc_pkg::CHAR_W-1:0]  name_byte;
    logic                        last_byte;
    logic [dsc_pkg::IDX_W-1:0]   rule_slot;
    logic [dsc_pkg::POS_W-1:0]   char_pos;
    logic [dsc_pkg::CHAR_W-1:0]  pattern_char;
    logic [dsc_pkg::LEN_W-1:0]   pattern_len;
    logic [dsc_pkg::APP_W-1:0]   app_value;

    modport source (output valid, kind, name_byte, last_byte, rule_slot, char_pos,
                    pattern_char, pattern_len, app_value, input ready);
    modport sink   (input valid, kind, name_byte, last_byte, rule_slot, char_pos,
                    pattern_char, pattern_len, app_value, output ready);
endinterface

interface dsc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       matched;
    logic [dsc_pkg::APP_W-1:0]  app_code;
    logic [dsc_pkg::IDX_W-1:0]  rule_index;

    modport source (output valid, matched, app_code, rule_index, input ready);
    modport sink   (input valid, matched, app_code, rule_index, output ready);
endinterface

>>> hdl/dsc_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module dsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/dsc_queue.sv
// Two-entry queue of finished name snapshots between front and back.
// No package dependencies.
module dsc_queue #(
    parameter int W = 270
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_valid,
    output logic         o_full,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_data [2];
    logic [1:0]   r_cnt, n_cnt;
    logic         r_rd, r_wr;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
        end
        if (i_push) begin
            r_data[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_data[r_rd];
endmodule

>>> hdl/dsc_front.sv
// Front end: takes input transfers, builds the lower-cased tail window and
// length, pushes snapshots on the last byte, forwards rule writes. Uses dsc_pkg.
module dsc_front #(
    parameter int MAX_SUFFIX_LEN = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    dsc_in_if.sink                 i_in,
    input  dsc_pkg::t_back_status  i_status,
    input  logic                   i_q_valid,
    input  logic                   i_q_full,
    output logic                   o_push,
    output logic [(MAX_SUFFIX_LEN+1)*dsc_pkg::CHAR_W+dsc_pkg::LEN_W-1:0] o_snap,
    output dsc_pkg::t_rule_wr      o_wr
);
    localparam int CW = dsc_pkg::CHAR_W;
    localparam int WB = (MAX_SUFFIX_LEN + 1) * CW;

    logic [WB-1:0]              r_win, n_win;
    logic [dsc_pkg::LEN_W-1:0]  r_len, n_len;
    logic [CW-1:0]              lc;
    logic                       accept;
    logic                       is_rule;

    assign is_rule = (i_in.kind == dsc_pkg::KIND_RULE);
    // rule writes wait until no scan is pending so a scan sees a stable table
    assign i_in.ready = is_rule ? (i_status.idle && !i_q_valid)
                                : (!i_in.last_byte || !i_q_full);
    assign accept = i_in.valid && i_in.ready;

    always_comb begin
        lc = i_in.name_byte;
        if (i_in.name_byte >= dsc_pkg::UPPER_A && i_in.name_byte <= dsc_pkg::UPPER_Z) begin
            lc = i_in.name_byte + dsc_pkg::CASE_OFS;
        end
    end

    always_comb begin
        n_win  = r_win;
        n_len  = r_len;
        o_push = 1'b0;
        o_snap = {r_win[WB-CW-1:0], lc,
                  (r_len == dsc_pkg::LEN_SAT) ? r_len : r_len + 6'd1};
        if (accept && !is_rule) begin
            if (i_in.last_byte) begin
                o_push = 1'b1;
                n_win  = '0;
                n_len  = '0;
            end else begin
                n_win = o_snap[WB+dsc_pkg::LEN_W-1:dsc_pkg::LEN_W];
                n_len = o_snap[dsc_pkg::LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_len <= '0;
        end else begin
            r_win <= n_win;
            r_len <= n_len;
        end
    end

    assign o_wr.en   = accept && is_rule;
    assign o_wr.slot = i_in.rule_slot;
    assign o_wr.pos  = i_in.char_pos;
    assign o_wr.ch   = i_in.pattern_char;
    assign o_wr.len  = i_in.pattern_len;
    assign o_wr.app  = i_in.app_value;
endmodule

>>> hdl/dsc_back.sv
// Back end: holds the rule table (pattern chars and per-rule length/app code
// in dsc_ram instances), scans it slot by slot and char by char for each
// snapshot, registers the result. Uses dsc_pkg and dsc_ram.
module dsc_back #(
    parameter int NUM_RULES      = 64,
    parameter int MAX_SUFFIX_LEN = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dsc_pkg::t_rule_wr      i_wr,
    input  logic                   i_q_valid,
    input  logic [(MAX_SUFFIX_LEN+1)*dsc_pkg::CHAR_W+dsc_pkg::LEN_W-1:0] i_snap,
    output logic                   o_pop,
    output dsc_pkg::t_back_status  o_status,
    dsc_out_if.source              o_out
);
    localparam int CW    = dsc_pkg::CHAR_W;
    localparam int LW    = dsc_pkg::LEN_W;
    localparam int IW    = dsc_pkg::IDX_W;
    localparam int MW    = dsc_pkg::LEN_W + dsc_pkg::APP_W;
    localparam int WB    = (MAX_SUFFIX_LEN + 1) * CW;
    localparam int SW    = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int CNTW  = $clog2(NUM_RULES + 1);
    localparam int DEPTH = NUM_RULES * MAX_SUFFIX_LEN;
    localparam int AW    = $clog2(DEPTH);

    // a slot counts as empty until its first write
    logic [NUM_RULES-1:0] r_vld;

    dsc_pkg::t_back_state r_state, n_state;
    logic [WB-1:0]        r_win;
    logic [LW-1:0]        r_nlen;
    logic [CNTW-1:0]      r_slot, n_slot;
    logic [LW-1:0]        r_p, n_p;
    logic                 r_hit, n_hit;
    logic                 r_ov, n_ov;
    logic                 r_matched;
    logic [dsc_pkg::APP_W-1:0] r_app;
    logic [IW-1:0]        r_idx;

    logic [AW-1:0]        raddr, waddr;
    logic [CW-1:0]        rdata;
    logic [SW-1:0]        meta_raddr;
    logic [MW-1:0]        meta_rdata;
    logic [LW-1:0]        cur_len;
    logic [dsc_pkg::APP_W-1:0] cur_app;
    logic [SW-1:0]        cur_slot;
    logic                 wr_ok;
    logic                 take;

    // rule table write: slots past the table are dropped, chars past the window too
    assign wr_ok = i_wr.en && ((CNTW+1)'(i_wr.slot) < (CNTW+1)'(NUM_RULES));
    assign waddr = AW'(AW'(i_wr.slot) * AW'(MAX_SUFFIX_LEN) + AW'(i_wr.pos));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_ok) begin
            r_vld[i_wr.slot[SW-1:0]] <= 1'b1;
        end
    end

    dsc_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_chars (
        .i_clk   (i_clk),
        .i_we    (wr_ok && (7'(i_wr.pos) < 7'(MAX_SUFFIX_LEN))),
        .i_waddr (waddr),
        .i_wdata (i_wr.ch),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // length and app code per slot; read address follows the next slot so
    // the registered data always belongs to the current slot
    dsc_ram #(.WIDTH(MW), .DEPTH(NUM_RULES)) u_meta (
        .i_clk   (i_clk),
        .i_we    (wr_ok),
        .i_waddr (i_wr.slot[SW-1:0]),
        .i_wdata ({i_wr.len, i_wr.app}),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    assign meta_raddr = n_slot[SW-1:0];
    assign cur_slot   = r_slot[SW-1:0];
    assign cur_len    = r_vld[cur_slot] ? meta_rdata[MW-1:dsc_pkg::APP_W] : '0;
    assign cur_app    = meta_rdata[dsc_pkg::APP_W-1:0];
    assign take       = o_out.valid && o_out.ready;

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_p     = r_p;
        n_hit   = r_hit;
        n_ov    = take ? 1'b0 : r_ov;
        o_pop   = 1'b0;
        raddr   = AW'(AW'(cur_slot) * AW'(MAX_SUFFIX_LEN));
        unique case (r_state)
            dsc_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_slot  = '0;
                    n_hit   = 1'b0;
                    n_state = dsc_pkg::BK_SLOT;
                end
            end
            dsc_pkg::BK_SLOT: begin
                n_p = '0;
                if (r_slot == CNTW'(NUM_RULES)) begin
                    n_state = dsc_pkg::BK_DONE;
                end else if (cur_len != '0 && 7'(cur_len) <= 7'(MAX_SUFFIX_LEN)
                             && r_nlen >= cur_len) begin
                    n_state = dsc_pkg::BK_CMP;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            dsc_pkg::BK_CMP: begin
                if (rdata != r_win[CW*r_p +: CW]) begin
                    n_slot  = r_slot + 1'b1;
                    n_state = dsc_pkg::BK_SLOT;
                end else if (r_p == cur_len - 1'b1) begin
                    if ((r_nlen == cur_len && r_nlen < dsc_pkg::LEN_SAT)
                        || r_win[CW*cur_len +: CW] == dsc_pkg::DOT_CHAR) begin
                        n_hit   = 1'b1;
                        n_state = dsc_pkg::BK_DONE;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = dsc_pkg::BK_SLOT;
                    end
                end else begin
                    n_p   = r_p + 1'b1;
                    raddr = AW'(AW'(cur_slot) * AW'(MAX_SUFFIX_LEN) + AW'(r_p + 1'b1));
                end
            end
            dsc_pkg::BK_DONE: begin
                if (!r_ov || take) begin
                    n_ov    = 1'b1;
                    n_state = dsc_pkg::BK_IDLE;
                end
            end
            default: n_state = dsc_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsc_pkg::BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_slot <= n_slot;
        r_p    <= n_p;
        r_hit  <= n_hit;
        if (o_pop) begin
            r_win  <= i_snap[WB+LW-1:LW];
            r_nlen <= i_snap[LW-1:0];
        end
        if (r_state == dsc_pkg::BK_DONE && (!r_ov || take)) begin
            r_matched <= r_hit;
            r_app     <= r_hit ? cur_app : '0;
            r_idx     <= r_hit ? IW'(r_slot) : '0;
        end
    end

    assign o_status.idle  = (r_state == dsc_pkg::BK_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.matched    = r_matched;
    assign o_out.app_code   = r_app;
    assign o_out.rule_index = r_idx;
endmodule

>>> hdl/domain_suffix_classifier.sv
// Domain suffix classifier. Name bytes transfer one per cycle, a last byte
// only while the snapshot queue is not full; rule writes one per cycle while
// no scan is pending. The scan visits the rules slot by slot and compares
// pattern chars one at a time through the single char RAM read port.
// Synchronous active-low reset clears window, length, rule valid flags (slots read empty), queue.
module domain_suffix_classifier #(
    parameter int NUM_RULES      = 64,
    parameter int MAX_SUFFIX_LEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dsc_in_if.sink     i_in,
    dsc_out_if.source  o_out
);
    // snapshot = tail window (newest byte lowest) plus saturated length
    localparam int SNAP_W = (MAX_SUFFIX_LEN + 1) * dsc_pkg::CHAR_W + dsc_pkg::LEN_W;

    dsc_pkg::t_back_status status;
    dsc_pkg::t_rule_wr     wr;
    logic                  push, pop, q_valid, q_full;
    logic [SNAP_W-1:0]     snap_in, snap_out;

    // front: window build, admission of rule writes
    dsc_front #(.MAX_SUFFIX_LEN(MAX_SUFFIX_LEN)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_status  (status),
        .i_q_valid (q_valid),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_snap    (snap_in),
        .o_wr      (wr)
    );

    // finished names wait here so the next name can stream in during a scan
    dsc_queue #(.W(SNAP_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (snap_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (snap_out)
    );

    // back: rule table and first-match scan, registered result
    dsc_back #(.NUM_RULES(NUM_RULES), .MAX_SUFFIX_LEN(MAX_SUFFIX_LEN)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_q_valid (q_valid),
        .i_snap    (snap_out),
        .o_pop     (pop),
        .o_status  (status),
        .o_out     (o_out)
    );
endmodule
